// ===== hw/rtl/bsi_pkg.sv =====
// ----------------------------------------------------------------------------
// bsi_pkg
// Shared types and constants for the bounded sorted insert block.
// ----------------------------------------------------------------------------
package bsi_pkg;

   localparam int CAPACITY     = 16;
   localparam int KEY_WIDTH    = 32;
   localparam int INDEX_WIDTH  = $clog2(CAPACITY);
   localparam int COUNT_WIDTH  = $clog2(CAPACITY + 1);
   localparam int CSR_WIDTH    = 5;

   // request mode codes
   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_READ   = 2'd1,
      MODE_CLEAR  = 2'd2,
      MODE_UNUSED = 2'd3
   } mode_type;

   // register indexes on the csr port
   typedef enum logic [0:0] {
      CSR_ASCENDING_ORDER = 1'b0,
      CSR_CAPACITY_IN_USE = 1'b1
   } csr_index_type;

   typedef logic signed [KEY_WIDTH-1:0] key_type;

   // per-cell control from the top level
   typedef struct packed {
      logic insert_en;     // an accepted insert that will be placed
      logic in_list;       // cell lies below the searched length
      logic fallback_slot; // cell is the append slot of a non-full list
      logic in_span;       // cell lies at or below the shift limit
   } cell_ctl_type;

endpackage

// ===== hw/rtl/bounded_sorted_insert.sv =====
// ----------------------------------------------------------------------------
// bounded_sorted_insert
// Bounded sorted list of signed keys (top-k), held in a row of cells.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  mode, key, read_index
//   rsp      out        rsp_valid / rsp_ready  position, accepted, entry_total,
//                                              read_key
//   csr      in         csr_we                 csr_index, csr_wdata
//
// one item per cycle while req_ready is high: every cell compares the key in
// parallel and shifts or loads in the accept cycle; the result sits in the
// response register the next cycle. req_ready is high while the response
// register is empty or being taken. synchronous reset empties the list and
// loads the register defaults; stored keys are not cleared.
// ----------------------------------------------------------------------------
module bounded_sorted_insert (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_mode,
   input  logic signed [bsi_pkg::KEY_WIDTH-1:0] req_key,
   input  logic [3:0]                           req_read_index,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [3:0]                           rsp_position,
   output logic                                 rsp_accepted,
   output logic [4:0]                           rsp_entry_total,
   output logic signed [bsi_pkg::KEY_WIDTH-1:0] rsp_read_key,
   input  logic                                 csr_we,
   input  logic [0:0]                           csr_index,
   input  logic [bsi_pkg::CSR_WIDTH-1:0]        csr_wdata
);

   localparam int CAP = bsi_pkg::CAPACITY;
   localparam int IW  = bsi_pkg::INDEX_WIDTH;
   localparam int CW  = bsi_pkg::COUNT_WIDTH;

   logic                       ascending_ff;
   logic [bsi_pkg::CSR_WIDTH-1:0] capacity_ff;
   logic [CW-1:0]              count_ff, count_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0]              position_ff, position_in;
   logic                       accepted_ff, accepted_in;
   logic [CW-1:0]              total_ff, total_in;
   bsi_pkg::key_type           read_key_ff, read_key_in;

   logic                       take;
   bsi_pkg::mode_type          mode;
   logic [CW-1:0]              cap_eff;
   logic                       full;
   logic [CW-1:0]              search_len;
   logic [CW-1:0]              last;
   logic                       last_before;
   logic                       insert_ok;
   logic [IW-1:0]              insert_pos;

   bsi_pkg::key_type           slot_key [CAP];
   bsi_pkg::key_type           prev_key [CAP];
   logic [CAP-1:0]             before_raw;
   logic [CAP-1:0]             place;
   logic [CAP:0]               found;
   bsi_pkg::cell_ctl_type      ctl [CAP];

   assign take      = req_valid & req_ready;
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign mode      = bsi_pkg::mode_type'(req_mode);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ascending_ff <= 1'b1;
         capacity_ff  <= bsi_pkg::CSR_WIDTH'(CAP);
      end else if (csr_we) begin
         unique case (bsi_pkg::csr_index_type'(csr_index))
            bsi_pkg::CSR_ASCENDING_ORDER: ascending_ff <= csr_wdata[0];
            bsi_pkg::CSR_CAPACITY_IN_USE: capacity_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective capacity, zero acts as one and large values clamp
   always_comb begin
      if (capacity_ff == '0) begin
         cap_eff = CW'(1);
      end else if (CW'(capacity_ff) > CW'(CAP) || capacity_ff > bsi_pkg::CSR_WIDTH'(CAP)) begin
         cap_eff = CW'(CAP);
      end else begin
         cap_eff = CW'(capacity_ff);
      end
   end

   assign full       = count_ff >= cap_eff;
   assign search_len = full ? cap_eff : count_ff;
   assign last       = full ? (cap_eff - CW'(1)) : count_ff;

   // reject test against the entry at capacity minus one
   always_comb begin
      last_before = 1'b0;
      for (int i = 0; i < CAP; i++) begin
         if (CW'(i) == cap_eff - CW'(1)) begin
            last_before = before_raw[i];
         end
      end
   end

   assign insert_ok = take & (mode == bsi_pkg::MODE_INSERT) & (~full | last_before);

   // row of cells with the found chain between neighbors
   assign found[0] = 1'b0;

   for (genvar g = 0; g < CAP; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign prev_key[g] = req_key;
      end else begin : g_body
         assign prev_key[g] = slot_key[g-1];
      end

      assign ctl[g].insert_en     = insert_ok;
      assign ctl[g].in_list       = CW'(g) < search_len;
      assign ctl[g].fallback_slot = ~full & (CW'(g) == count_ff);
      assign ctl[g].in_span       = CW'(g) <= last;

      bsi_cell u_cell (
         .clock      (clock),
         .ascending  (ascending_ff),
         .new_key    (req_key),
         .prev_key   (prev_key[g]),
         .found_in   (found[g]),
         .ctl        (ctl[g]),
         .slot_key   (slot_key[g]),
         .before_raw (before_raw[g]),
         .found_out  (found[g+1]),
         .place      (place[g])
      );
   end

   // encode the one-hot insertion point
   always_comb begin
      insert_pos = '0;
      for (int i = 0; i < CAP; i++) begin
         if (place[i]) begin
            insert_pos = insert_pos | IW'(i);
         end
      end
   end

   // entry count and response contents
   always_comb begin
      count_in    = count_ff;
      position_in = '0;
      accepted_in = 1'b0;
      read_key_in = '0;
      unique case (mode)
         bsi_pkg::MODE_INSERT: begin
            if (insert_ok) begin
               count_in    = full ? cap_eff : (count_ff + CW'(1));
               position_in = insert_pos;
               accepted_in = 1'b1;
            end
         end
         bsi_pkg::MODE_READ: begin
            position_in = req_read_index;
            if (CW'(req_read_index) < count_ff) begin
               accepted_in = 1'b1;
               read_key_in = slot_key[req_read_index];
            end
         end
         bsi_pkg::MODE_CLEAR: begin
            count_in = '0;
         end
         default: ;
      endcase
      total_in = count_in;
   end

   assign rsp_valid_in = take | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, loaded on accept
   always_ff @(posedge clock) begin
      if (take) begin
         position_ff <= position_in;
         accepted_ff <= accepted_in;
         total_ff    <= total_in;
         read_key_ff <= read_key_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_position    = position_ff;
   assign rsp_accepted    = accepted_ff;
   assign rsp_entry_total = total_ff;
   assign rsp_read_key    = read_key_ff;

endmodule

// ===== hw/rtl/bsi_cell.sv =====
// ----------------------------------------------------------------------------
// bsi_cell
// One list slot: holds a key, compares it to the incoming key and either
// keeps it, takes the new key, or takes its upstream neighbor's key.
// ----------------------------------------------------------------------------
module bsi_cell (
   input  logic                  clock,
   input  logic                  ascending,
   input  bsi_pkg::key_type      new_key,
   input  bsi_pkg::key_type      prev_key,
   input  logic                  found_in,
   input  bsi_pkg::cell_ctl_type ctl,
   output bsi_pkg::key_type      slot_key,
   output logic                  before_raw,
   output logic                  found_out,
   output logic                  place
);

   bsi_pkg::key_type slot_key_ff;
   bsi_pkg::key_type slot_key_in;
   logic             lt_gated;
   logic             shift;

   // new key orders strictly before the held key
   assign before_raw = ascending ? (new_key < slot_key_ff) : (new_key > slot_key_ff);
   assign lt_gated   = before_raw & ctl.in_list;
   assign found_out  = found_in | lt_gated;

   // insertion point is the first hit, or the append slot when none hit
   assign place = ctl.insert_en & ~found_in & (lt_gated | ctl.fallback_slot);
   assign shift = ctl.insert_en & found_in & ctl.in_span;

   always_comb begin
      slot_key_in = slot_key_ff;
      if (place) begin
         slot_key_in = new_key;
      end else if (shift) begin
         slot_key_in = prev_key;
      end
   end

   always_ff @(posedge clock) begin
      slot_key_ff <= slot_key_in;
   end

   assign slot_key = slot_key_ff;

endmodule
